@@ rtl/core/tphd_pkg.sv @@
// Package with types, character codes and the decimal field scanner for the header deframer.
`timescale 1ns / 1ps
`default_nettype none

package tphd_pkg;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [23:0] TERM_PREFIX = {CH_CR, CH_LF, CH_CR};

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_DROP    = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		SC_SKIP   = 2'd0,
		SC_DIGITS = 2'd1,
		SC_DONE   = 2'd2
	} scan_phase_t;

	typedef struct packed {
		logic [31:0] val;
		logic        neg;
		scan_phase_t sp;
	} scan_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic scan_t scan_byte(input logic [7:0] c, input scan_t cur);
		scan_t nxt;
		logic digit;
		logic [31:0] dval;
		nxt = cur;
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		dval = {24'd0, c - CH_ZERO};
		unique case (cur.sp)
			SC_SKIP: begin
				if (is_ws(c)) begin
					nxt = cur;
				end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
					nxt.neg = (c == CH_MINUS);
					nxt.sp = SC_DIGITS;
				end else if (digit) begin
					nxt.val = (cur.val << 3) + (cur.val << 1) + dval;
					nxt.sp = SC_DIGITS;
				end else begin
					nxt.sp = SC_DONE;
				end
			end
			SC_DIGITS: begin
				if (digit) begin
					nxt.val = (cur.val << 3) + (cur.val << 1) + dval;
				end else begin
					nxt.sp = SC_DONE;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
		return nxt;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/text_packet_header_deframer_top.sv @@
// Top level of the text packet header deframer: input stage, parser state and result register.
//
// The input channel takes one packet byte per transaction with an end-of-packet mark.
// Header bytes are scanned for the CR LF CR LF terminator while the sequence number and
// the packet count are parsed as decimal text. When the terminator arrives one header
// transaction is issued, and each later byte of the packet is passed on as a payload
// transaction. A packet that ends inside its header, or a header without a space, gives
// one error transaction. Bytes beyond MAX_PACKET_BYTES in a packet are ignored.
// An accepted byte is held in the input register, then its result in the result register.
// Throughput is one byte per cycle unless out_ready stalls: a byte's parse is one scanner
// pass with its shift-and-add multiply by ten between the input and result registers.
// Reset clears the parser to the start of a packet and empties both registers.
// When the receiver holds out_ready low, the result register holds its transaction and
// one more byte waits in the input register; in_ready then falls until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module text_packet_header_deframer_top #(
	parameter int MAX_PACKET_BYTES = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         data_byte,
	input  wire logic               packet_end,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              kind,
	output logic [7:0]              payload_byte,
	output logic signed [31:0]      sequence_number,
	output logic signed [31:0]      packet_count,
	output logic [10:0]             header_length,
	output logic                    is_final,
	output logic                    ends_packet
);

	localparam int PosW = $clog2(MAX_PACKET_BYTES + 1);
	localparam logic [PosW-1:0] PosMax = PosW'(MAX_PACKET_BYTES);

	logic                    valid_s1;
	logic [7:0]              data_s1;
	logic                    end_s1;
	logic                    advance;

	tphd_pkg::phase_t        phase_q, phase_d;
	logic [23:0]             tail_q, tail_d;
	logic [PosW-1:0]         pos_q, pos_d;
	logic                    space_q, space_d;
	logic                    cr_q, cr_d;
	tphd_pkg::scan_t         seq_q, seq_d;
	tphd_pkg::scan_t         cnt_q, cnt_d;

	logic                    in_limit;
	logic                    term;
	logic [31:0]             pos_ext;
	logic [31:0]             seq_out;
	logic [31:0]             cnt_out;
	logic                    res_valid;
	logic [1:0]              res_kind;
	logic [7:0]              res_payload;
	logic [31:0]             res_seq;
	logic [31:0]             res_cnt;
	logic [10:0]             res_hlen;
	logic                    res_final;

	logic                    out_valid_q;
	logic [1:0]              kind_q;
	logic [7:0]              payload_q;
	logic [31:0]             seq_res_q;
	logic [31:0]             cnt_res_q;
	logic [10:0]             hlen_q;
	logic                    final_q;
	logic                    end_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			end_s1  <= packet_end;
		end
	end

	assign in_limit = pos_q < PosMax;
	assign term     = (tail_q == tphd_pkg::TERM_PREFIX) && (data_s1 == tphd_pkg::CH_LF);
	assign pos_ext  = 32'(pos_q) + 32'd1;

	always_comb begin
		phase_d     = phase_q;
		tail_d      = tail_q;
		pos_d       = pos_q;
		space_d     = space_q;
		cr_d        = cr_q;
		seq_d       = seq_q;
		cnt_d       = cnt_q;
		seq_out     = 32'd0;
		cnt_out     = 32'd0;
		res_valid   = 1'b0;
		res_kind    = tphd_pkg::KIND_HEADER;
		res_payload = 8'd0;
		res_seq     = 32'd0;
		res_cnt     = 32'd0;
		res_hlen    = 11'd0;
		res_final   = 1'b0;
		if (in_limit) begin
			pos_d = pos_q + PosW'(1);
		end
		unique case (phase_q)
			tphd_pkg::PH_HEADER: begin
				if (in_limit) begin
					if (!space_q) begin
						if (data_s1 == tphd_pkg::CH_SP) begin
							space_d = 1'b1;
						end else begin
							seq_d = tphd_pkg::scan_byte(data_s1, seq_q);
						end
					end else if (!cr_q && (data_s1 != tphd_pkg::CH_CR)) begin
						cnt_d = tphd_pkg::scan_byte(data_s1, cnt_q);
					end
					if (data_s1 == tphd_pkg::CH_CR) begin
						cr_d = 1'b1;
					end
					tail_d = {tail_q[15:0], data_s1};
					if (term) begin
						res_valid = 1'b1;
						if (space_d) begin
							seq_out   = seq_d.neg ? (32'd0 - seq_d.val) : seq_d.val;
							cnt_out   = cnt_d.neg ? (32'd0 - cnt_d.val) : cnt_d.val;
							res_kind  = tphd_pkg::KIND_HEADER;
							res_seq   = seq_out;
							res_cnt   = cnt_out;
							res_hlen  = pos_ext[10:0];
							res_final = $signed(seq_out) >= $signed(cnt_out);
							phase_d   = tphd_pkg::PH_PAYLOAD;
						end else begin
							res_kind = tphd_pkg::KIND_ERROR;
							phase_d  = tphd_pkg::PH_DROP;
						end
					end
				end
				if (!res_valid && end_s1) begin
					res_valid = 1'b1;
					res_kind  = tphd_pkg::KIND_ERROR;
				end
			end
			tphd_pkg::PH_PAYLOAD: begin
				if (in_limit) begin
					res_valid   = 1'b1;
					res_kind    = tphd_pkg::KIND_PAYLOAD;
					res_payload = data_s1;
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
		if (end_s1) begin
			phase_d = tphd_pkg::PH_HEADER;
			tail_d  = 24'd0;
			pos_d   = '0;
			space_d = 1'b0;
			cr_d    = 1'b0;
			seq_d   = '{val: 32'd0, neg: 1'b0, sp: tphd_pkg::SC_SKIP};
			cnt_d   = '{val: 32'd0, neg: 1'b0, sp: tphd_pkg::SC_SKIP};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tphd_pkg::PH_HEADER;
			tail_q  <= 24'd0;
			pos_q   <= '0;
			space_q <= 1'b0;
			cr_q    <= 1'b0;
			seq_q   <= '{val: 32'd0, neg: 1'b0, sp: tphd_pkg::SC_SKIP};
			cnt_q   <= '{val: 32'd0, neg: 1'b0, sp: tphd_pkg::SC_SKIP};
		end else if (advance) begin
			phase_q <= phase_d;
			tail_q  <= tail_d;
			pos_q   <= pos_d;
			space_q <= space_d;
			cr_q    <= cr_d;
			seq_q   <= seq_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			kind_q    <= res_kind;
			payload_q <= res_payload;
			seq_res_q <= res_seq;
			cnt_res_q <= res_cnt;
			hlen_q    <= res_hlen;
			final_q   <= res_final;
			end_q     <= end_s1;
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = kind_q;
	assign payload_byte    = payload_q;
	assign sequence_number = seq_res_q;
	assign packet_count    = cnt_res_q;
	assign header_length   = hlen_q;
	assign is_final        = final_q;
	assign ends_packet     = end_q;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("Input stage is empty but in_ready is low.");

	a_restart_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		advance && end_s1 |=> (phase_q == tphd_pkg::PH_HEADER) && (pos_q == '0) && !space_q)
		else $error("Parser did not return to the packet start after a final byte.");

	a_payload_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == tphd_pkg::KIND_PAYLOAD) |->
			(sequence_number == 32'sd0) && (packet_count == 32'sd0) && (header_length == 11'd0))
		else $error("Payload transaction carries header fields.");

	a_header_length_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == tphd_pkg::KIND_HEADER) |-> (header_length >= 11'd4))
		else $error("Header transaction shorter than its terminator.");

	a_no_payload_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != tphd_pkg::KIND_PAYLOAD) |-> (payload_byte == 8'd0))
		else $error("Non-payload transaction carries a payload byte.");

endmodule

`default_nettype wire
